[design/kpsd_pkg.sv]
// Package with the item types, constants and key map of the keypad scan and debounce unit.
`timescale 1ns / 1ps

package kpsd_pkg;

  typedef struct packed {
    logic       kind;
    logic [3:0] cols_row4;
    logic [3:0] cols_row3;
    logic [3:0] cols_row2;
    logic [3:0] cols_row1;
  } in_item_t;

  typedef struct packed {
    logic       result_kind;
    logic [7:0] key_value;
  } out_item_t;

  typedef struct packed {
    logic       hit;
    logic [7:0] key;
  } lane_hit_t;

  localparam logic KIND_SCAN = 1'b0;
  localparam logic KIND_READ = 1'b1;

  localparam logic [7:0] NO_KEY     = 8'h00;
  localparam logic [7:0] HELD_KEY   = 8'hFF;
  localparam logic [7:0] NONE_READY = 8'hFF;

  localparam logic [3:0] THRESHOLD_RESET = 4'd3;
  localparam logic [3:0] COUNT_MAX       = 4'hF;

  localparam logic [3:0] COL_C4_LOW = 4'h7;
  localparam logic [3:0] COL_C3_LOW = 4'hB;
  localparam logic [3:0] COL_C2_LOW = 4'hD;
  localparam logic [3:0] COL_C1_LOW = 4'hE;

  function automatic logic [7:0] key_code(input logic [1:0] row, input logic [1:0] col);
    logic [7:0] code;
    begin
      case ({row, col})
        4'b00_00: code = "1";
        4'b00_01: code = "2";
        4'b00_10: code = "3";
        4'b00_11: code = "A";
        4'b01_00: code = "4";
        4'b01_01: code = "5";
        4'b01_10: code = "6";
        4'b01_11: code = "B";
        4'b10_00: code = "7";
        4'b10_01: code = "8";
        4'b10_10: code = "9";
        4'b10_11: code = "C";
        4'b11_00: code = "*";
        4'b11_01: code = "0";
        4'b11_10: code = "#";
        default:  code = "D";
      endcase
      return code;
    end
  endfunction

endpackage

[design/kpsd_row_lane.sv]
// One row lane: finds the single low column of a row sample and gives its key code.
`timescale 1ns / 1ps

module kpsd_row_lane (
  input  logic [1:0]         row,
  input  logic [3:0]         cols,
  output kpsd_pkg::lane_hit_t result
);

  logic [1:0] col;

  always_comb begin
    case (cols)
      kpsd_pkg::COL_C4_LOW: col = 2'd3;
      kpsd_pkg::COL_C3_LOW: col = 2'd2;
      kpsd_pkg::COL_C2_LOW: col = 2'd1;
      default:              col = 2'd0;
    endcase
    result.hit = cols inside {kpsd_pkg::COL_C4_LOW, kpsd_pkg::COL_C3_LOW,
                              kpsd_pkg::COL_C2_LOW, kpsd_pkg::COL_C1_LOW};
    result.key = kpsd_pkg::key_code(row, col);
  end

endmodule

[design/kpsd_debounce.sv]
// Merge of the row lanes by priority, debounce counter and one-character latch.
`timescale 1ns / 1ps

module kpsd_debounce (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  logic                kind,
  input  kpsd_pkg::lane_hit_t lanes [4],
  input  logic [3:0]          threshold,
  output logic [7:0]          value
);

  logic [7:0] previous_key;
  logic [3:0] repeat_count;
  logic       key_ready;
  logic [7:0] latched_key;

  logic [7:0] previous_key_next;
  logic [3:0] repeat_count_next;
  logic       key_ready_next;
  logic [7:0] latched_key_next;

  kpsd_pkg::lane_hit_t pick;
  logic [3:0]          count_step;

  always_comb begin
    if (lanes[3].hit) begin
      pick = lanes[3];
    end else if (lanes[2].hit) begin
      pick = lanes[2];
    end else if (lanes[1].hit) begin
      pick = lanes[1];
    end else begin
      pick = lanes[0];
    end

    previous_key_next = previous_key;
    repeat_count_next = repeat_count;
    key_ready_next    = key_ready;
    latched_key_next  = latched_key;

    if (repeat_count < kpsd_pkg::COUNT_MAX) begin
      count_step = repeat_count + 4'd1;
    end else begin
      count_step = repeat_count;
    end

    if (kind == kpsd_pkg::KIND_READ) begin
      if (key_ready) begin
        key_ready_next = 1'b0;
        value          = latched_key;
      end else begin
        value = kpsd_pkg::NONE_READY;
      end
    end else if (!pick.hit) begin
      previous_key_next = kpsd_pkg::NO_KEY;
      repeat_count_next = 4'd0;
      value             = kpsd_pkg::NO_KEY;
    end else if (pick.key == previous_key && repeat_count > threshold) begin
      value = kpsd_pkg::HELD_KEY;
    end else begin
      if (pick.key == previous_key) begin
        repeat_count_next = count_step;
      end else begin
        repeat_count_next = 4'd0;
      end
      previous_key_next = pick.key;
      if (repeat_count_next == threshold) begin
        key_ready_next   = 1'b1;
        latched_key_next = pick.key;
      end
      value = pick.key;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_key <= kpsd_pkg::NO_KEY;
      repeat_count <= 4'd0;
      key_ready    <= 1'b0;
      latched_key  <= 8'h00;
    end else if (accept) begin
      previous_key <= previous_key_next;
      repeat_count <= repeat_count_next;
      key_ready    <= key_ready_next;
      latched_key  <= latched_key_next;
    end
  end

endmodule

[design/kpsd_out_buf.sv]
// Two-entry output buffer that keeps the input side open while a result waits.
`timescale 1ns / 1ps

module kpsd_out_buf (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  kpsd_pkg::out_item_t push_item,
  output logic                space,
  output logic                out_valid,
  input  logic                out_ready,
  output kpsd_pkg::out_item_t out_item
);

  logic                skid_valid;
  kpsd_pkg::out_item_t skid_item;
  logic                pop;

  assign pop   = out_valid && out_ready;
  assign space = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        skid_valid <= 1'b0;
      end
    end else if (push) begin
      if (out_valid && !pop) begin
        skid_valid <= 1'b1;
      end else begin
        out_valid <= 1'b1;
      end
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (pop) begin
        out_item <= skid_item;
      end
    end else if (push) begin
      if (out_valid && !pop) begin
        skid_item <= push_item;
      end else begin
        out_item <= push_item;
      end
    end
  end

endmodule

[design/keypad_scan_debounce_unit.sv]
// Top level of the keypad scan and debounce unit.
`timescale 1ns / 1ps

// The unit takes one item per clock cycle while in_ready is high. Four row lanes decode the four
// column samples of a scan tick side by side, a priority merge picks the first match from row 4
// down to row 1, and the debounce counter and character latch update in the same cycle. The
// result is registered in the output buffer. A two-entry output buffer holds results while the
// consumer stalls, so in_ready drops only when two results are waiting.
module keypad_scan_debounce_unit (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [3:0]          cfg_wdata,
  input  logic                in_valid,
  output logic                in_ready,
  input  kpsd_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output kpsd_pkg::out_item_t out_item
);

  logic [3:0]          debounce_threshold;
  logic                accept;
  logic [3:0]          row_cols [4];
  kpsd_pkg::lane_hit_t lanes [4];
  logic [7:0]          value;
  kpsd_pkg::out_item_t result;

  assign accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_threshold <= kpsd_pkg::THRESHOLD_RESET;
    end else if (cfg_we) begin
      debounce_threshold <= cfg_wdata;
    end
  end

  assign row_cols[0] = in_item.cols_row1;
  assign row_cols[1] = in_item.cols_row2;
  assign row_cols[2] = in_item.cols_row3;
  assign row_cols[3] = in_item.cols_row4;

  for (genvar r = 0; r < 4; r++) begin : g_lane
    kpsd_row_lane u_lane (
      .row    (2'(r)),
      .cols   (row_cols[r]),
      .result (lanes[r])
    );
  end

  kpsd_debounce u_debounce (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .kind      (in_item.kind),
    .lanes     (lanes),
    .threshold (debounce_threshold),
    .value     (value)
  );

  assign result.result_kind = in_item.kind;
  assign result.key_value   = value;

  kpsd_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .push_item (result),
    .space     (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule

[design/kpsd_checker.sv]
// Port checker for the keypad scan and debounce unit, bound to the top level.
`timescale 1ns / 1ps

module kpsd_checker (
  input logic                clk,
  input logic                rst,
  input logic                cfg_we,
  input logic [3:0]          cfg_wdata,
  input logic                in_valid,
  input logic                in_ready,
  input kpsd_pkg::in_item_t  in_item,
  input logic                out_valid,
  input logic                out_ready,
  input kpsd_pkg::out_item_t out_item
);

  // A stalled result stays put until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("stalled result changed");

  // The input side closes only when results are waiting.
  a_ready_needs_result: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid)
    else $error("input blocked with no result waiting");

  // A scan result is none, held, or one of the sixteen key codes.
  a_scan_code: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.result_kind == kpsd_pkg::KIND_SCAN |->
      out_item.key_value == kpsd_pkg::NO_KEY || out_item.key_value == kpsd_pkg::HELD_KEY ||
      out_item.key_value == 8'h23 || out_item.key_value == 8'h2A ||
      (out_item.key_value >= 8'h30 && out_item.key_value <= 8'h39) ||
      (out_item.key_value >= 8'h41 && out_item.key_value <= 8'h44))
    else $error("scan result is not a valid key code");

  // Reset empties the output buffer and opens the input side.
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) && !rst |-> !out_valid && in_ready)
    else $error("buffer not empty after reset");

endmodule

bind keypad_scan_debounce_unit kpsd_checker u_kpsd_checker (.*);

[dv/tb_top.sv]
// Self-checking testbench for the keypad scan and debounce unit, with a built-in key predictor.
`timescale 1ns / 1ps

module tb_top;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int LONG_HOLD      = 200;
  localparam int PHASE_ITEMS    = 220;

  localparam logic [3:0] NO_PRESS = 4'hF;
  localparam logic [3:0] ALL_LOW  = 4'h0;

  localparam logic [7:0] KEYPAD [4][4] = '{
    '{"1", "2", "3", "A"},
    '{"4", "5", "6", "B"},
    '{"7", "8", "9", "C"},
    '{"*", "0", "#", "D"}
  };

  typedef struct packed {
    kpsd_pkg::in_item_t item;
    logic               typed;
    logic [7:0]         key;
  } script_row_t;

  localparam script_row_t SCRIPT [0:24] = '{
    {kpsd_pkg::KIND_READ, NO_PRESS, NO_PRESS, NO_PRESS, NO_PRESS, 1'b1, kpsd_pkg::NONE_READY},
    {kpsd_pkg::KIND_SCAN, NO_PRESS, NO_PRESS, NO_PRESS, NO_PRESS, 1'b1, kpsd_pkg::NO_KEY},
    {kpsd_pkg::KIND_SCAN, kpsd_pkg::COL_C4_LOW, NO_PRESS, NO_PRESS, NO_PRESS, 1'b1, 8'("D")},
    {kpsd_pkg::KIND_SCAN, kpsd_pkg::COL_C1_LOW, ALL_LOW, ALL_LOW, ALL_LOW, 1'b0, 8'h00},
    {kpsd_pkg::KIND_SCAN, NO_PRESS, NO_PRESS, NO_PRESS, kpsd_pkg::COL_C1_LOW, 1'b0, 8'h00},
    {kpsd_pkg::KIND_SCAN, NO_PRESS, NO_PRESS, NO_PRESS, kpsd_pkg::COL_C1_LOW, 1'b0, 8'h00},
    {kpsd_pkg::KIND_SCAN, NO_PRESS, NO_PRESS, NO_PRESS, kpsd_pkg::COL_C1_LOW, 1'b0, 8'h00},
    {kpsd_pkg::KIND_SCAN, NO_PRESS, NO_PRESS, NO_PRESS, kpsd_pkg::COL_C1_LOW, 1'b0, 8'h00},
    {kpsd_pkg::KIND_SCAN, NO_PRESS, NO_PRESS, NO_PRESS, kpsd_pkg::COL_C1_LOW, 1'b0, 8'h00},
    {kpsd_pkg::KIND_SCAN, NO_PRESS, NO_PRESS, NO_PRESS, kpsd_pkg::COL_C1_LOW, 1'b0, 8'h00},
    {kpsd_pkg::KIND_READ, ALL_LOW, ALL_LOW, ALL_LOW, ALL_LOW, 1'b0, 8'h00},
    {kpsd_pkg::KIND_READ, NO_PRESS, NO_PRESS, NO_PRESS, NO_PRESS, 1'b1, kpsd_pkg::NONE_READY},
    {kpsd_pkg::KIND_SCAN, ALL_LOW, kpsd_pkg::COL_C3_LOW, kpsd_pkg::COL_C1_LOW, NO_PRESS,
     1'b0, 8'h00},
    {kpsd_pkg::KIND_SCAN, NO_PRESS, NO_PRESS, kpsd_pkg::COL_C2_LOW, NO_PRESS, 1'b0, 8'h00},
    {kpsd_pkg::KIND_SCAN, NO_PRESS, NO_PRESS, kpsd_pkg::COL_C4_LOW, NO_PRESS, 1'b0, 8'h00},
    {kpsd_pkg::KIND_SCAN, NO_PRESS, kpsd_pkg::COL_C1_LOW, NO_PRESS, NO_PRESS, 1'b0, 8'h00},
    {kpsd_pkg::KIND_SCAN, 4'h3, NO_PRESS, NO_PRESS, kpsd_pkg::COL_C3_LOW, 1'b0, 8'h00},
    {kpsd_pkg::KIND_SCAN, kpsd_pkg::COL_C2_LOW, NO_PRESS, NO_PRESS, NO_PRESS, 1'b0, 8'h00},
    {kpsd_pkg::KIND_SCAN, kpsd_pkg::COL_C3_LOW, NO_PRESS, NO_PRESS, NO_PRESS, 1'b0, 8'h00},
    {kpsd_pkg::KIND_SCAN, NO_PRESS, NO_PRESS, NO_PRESS, kpsd_pkg::COL_C4_LOW, 1'b0, 8'h00},
    {kpsd_pkg::KIND_SCAN, NO_PRESS, NO_PRESS, NO_PRESS, kpsd_pkg::COL_C2_LOW, 1'b0, 8'h00},
    {kpsd_pkg::KIND_SCAN, NO_PRESS, NO_PRESS, kpsd_pkg::COL_C1_LOW, NO_PRESS, 1'b0, 8'h00},
    {kpsd_pkg::KIND_SCAN, NO_PRESS, NO_PRESS, kpsd_pkg::COL_C3_LOW, NO_PRESS, 1'b0, 8'h00},
    {kpsd_pkg::KIND_SCAN, NO_PRESS, kpsd_pkg::COL_C2_LOW, NO_PRESS, NO_PRESS, 1'b0, 8'h00},
    {kpsd_pkg::KIND_SCAN, NO_PRESS, kpsd_pkg::COL_C4_LOW, NO_PRESS, NO_PRESS, 1'b0, 8'h00}
  };

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                cfg_we = 1'b0;
  logic [3:0]          cfg_wdata = 4'd0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  kpsd_pkg::in_item_t  in_item = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  kpsd_pkg::out_item_t out_item;

  logic       typed_check = 1'b0;
  logic [7:0] typed_key = 8'h00;
  logic       quiet = 1'b0;
  logic       hold_request = 1'b0;
  logic       hold_issued = 1'b0;

  logic [3:0] shadow_threshold;
  logic [7:0] last_key;
  logic [3:0] repeat_count;
  logic       char_pending;
  logic [7:0] char_latch;

  kpsd_pkg::out_item_t expected_keys [$];
  int                  error_count = 0;
  int                  idle_cycles = 0;
  int                  items_sent = 0;
  int                  results_checked = 0;
  int                  held_seen = 0;
  int                  chars_read = 0;

  keypad_scan_debounce_unit dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic int low_column(input logic [3:0] cols);
    int col;
    case (cols)
      kpsd_pkg::COL_C4_LOW: col = 3;
      kpsd_pkg::COL_C3_LOW: col = 2;
      kpsd_pkg::COL_C2_LOW: col = 1;
      kpsd_pkg::COL_C1_LOW: col = 0;
      default:              col = -1;
    endcase
    return col;
  endfunction

  // Advances the debounce state by one item and returns the answer it should produce.
  function automatic kpsd_pkg::out_item_t debounce_step(input kpsd_pkg::in_item_t it);
    kpsd_pkg::out_item_t res;
    logic [3:0]          lanes [4];
    logic [7:0]          key;
    logic                hit;
    int                  col;
    lanes[0] = it.cols_row1;
    lanes[1] = it.cols_row2;
    lanes[2] = it.cols_row3;
    lanes[3] = it.cols_row4;
    res.result_kind = it.kind;
    hit = 1'b0;
    key = kpsd_pkg::NO_KEY;
    if (it.kind == kpsd_pkg::KIND_READ) begin
      if (char_pending) begin
        char_pending = 1'b0;
        res.key_value = char_latch;
      end else begin
        res.key_value = kpsd_pkg::NONE_READY;
      end
    end else begin
      for (int r = 3; r >= 0; r--) begin
        col = low_column(lanes[r]);
        if (!hit && col >= 0) begin
          hit = 1'b1;
          key = KEYPAD[r][col];
        end
      end
      if (!hit) begin
        last_key = kpsd_pkg::NO_KEY;
        repeat_count = 4'd0;
        res.key_value = kpsd_pkg::NO_KEY;
      end else if (key == last_key && repeat_count > shadow_threshold) begin
        res.key_value = kpsd_pkg::HELD_KEY;
      end else begin
        if (key != last_key) begin
          repeat_count = 4'd0;
        end else if (repeat_count != kpsd_pkg::COUNT_MAX) begin
          repeat_count = repeat_count + 4'd1;
        end
        last_key = key;
        if (repeat_count == shadow_threshold) begin
          char_pending = 1'b1;
          char_latch = key;
        end
        res.key_value = key;
      end
    end
    return res;
  endfunction

  always @(posedge clk) begin
    kpsd_pkg::out_item_t want;
    if (rst) begin
      shadow_threshold = kpsd_pkg::THRESHOLD_RESET;
      last_key = kpsd_pkg::NO_KEY;
      repeat_count = 4'd0;
      char_pending = 1'b0;
      char_latch = 8'h00;
      idle_cycles = 0;
    end else begin
      if (cfg_we) begin
        shadow_threshold = cfg_wdata;
      end
      if (in_valid && in_ready) begin
        want = debounce_step(in_item);
        if (typed_check) begin
          want.key_value = typed_key;
        end
        expected_keys.push_back(want);
      end
      if (out_valid && out_ready) begin
        if (expected_keys.size() == 0) begin
          $error("Result arrived with no item outstanding: kind %0d, key_value %0d",
                 out_item.result_kind, out_item.key_value);
          error_count++;
        end else begin
          want = expected_keys.pop_front();
          results_checked++;
          if (out_item.result_kind !== want.result_kind) begin
            $error("result_kind: expected %0d, got %0d", want.result_kind,
                   out_item.result_kind);
            error_count++;
          end
          if (out_item.key_value !== want.key_value) begin
            $error("key_value: expected %0d, got %0d", want.key_value, out_item.key_value);
            error_count++;
          end
          if (want.result_kind == kpsd_pkg::KIND_SCAN &&
              want.key_value == kpsd_pkg::HELD_KEY) held_seen++;
          if (want.result_kind == kpsd_pkg::KIND_READ &&
              want.key_value != kpsd_pkg::NONE_READY) chars_read++;
        end
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
  end

  initial begin
    while (idle_cycles < WATCHDOG_LIMIT) @(posedge clk);
    $display("Watchdog: no item moved for %0d cycles", WATCHDOG_LIMIT);
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    int k;
    wait (rst === 1'b0);
    forever begin
      @(negedge clk);
      if (hold_request) begin
        out_ready <= 1'b0;
        for (k = 1; k < LONG_HOLD; k++) @(negedge clk);
        hold_request = 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(0, 9)) @(negedge clk);
      end
      @(negedge clk);
      out_ready <= 1'b1;
    end
  end

  task automatic push(input kpsd_pkg::in_item_t it, input logic typed, input logic [7:0] key);
    @(negedge clk);
    in_valid <= 1'b1;
    in_item <= it;
    typed_check <= typed;
    typed_key <= key;
    do @(posedge clk); while (!in_ready);
    items_sent++;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat ($urandom_range(0, 9)) @(negedge clk);
    end
  endtask

  task automatic set_threshold(input logic [3:0] value);
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_keys.size() != 0) @(negedge clk);
    repeat (2) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [3:0] quiet_nibble();
    logic [3:0] v;
    do v = 4'($urandom_range(0, 15)); while (low_column(v) >= 0);
    return v;
  endfunction

  // A scan that resolves to the given key: rows of higher priority show no single low
  // line, rows of lower priority carry anything.
  function automatic kpsd_pkg::in_item_t press(input int row, input int col);
    kpsd_pkg::in_item_t it;
    logic [3:0]         lanes [4];
    for (int r = 0; r < 4; r++) begin
      if (r > row) begin
        lanes[r] = ($urandom_range(0, 3) == 0) ? quiet_nibble() : NO_PRESS;
      end else begin
        lanes[r] = 4'($urandom_range(0, 15));
      end
    end
    case (col)
      0:       lanes[row] = kpsd_pkg::COL_C1_LOW;
      1:       lanes[row] = kpsd_pkg::COL_C2_LOW;
      2:       lanes[row] = kpsd_pkg::COL_C3_LOW;
      default: lanes[row] = kpsd_pkg::COL_C4_LOW;
    endcase
    it.kind = kpsd_pkg::KIND_SCAN;
    it.cols_row1 = lanes[0];
    it.cols_row2 = lanes[1];
    it.cols_row3 = lanes[2];
    it.cols_row4 = lanes[3];
    return it;
  endfunction

  // Mostly held keys of random length, with reads mixed in, plus noise and lone reads.
  task automatic run_phase(input int budget, input int stall_at);
    int                 start;
    int                 row;
    int                 col;
    int                 burst;
    kpsd_pkg::in_item_t it;
    start = items_sent;
    while (items_sent - start < budget) begin
      if (stall_at >= 0 && !hold_issued && items_sent - start >= stall_at) begin
        hold_request = 1'b1;
        hold_issued = 1'b1;
      end
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5, 6: begin
          row = $urandom_range(0, 3);
          col = $urandom_range(0, 3);
          burst = $urandom_range(1, 20);
          for (int k = 0; k < burst; k++) begin
            if ($urandom_range(0, 15) == 0) begin
              it = kpsd_pkg::in_item_t'(17'($urandom_range(0, 131071)));
              it.kind = kpsd_pkg::KIND_READ;
              push(it, 1'b0, 8'h00);
            end
            push(press(row, col), 1'b0, 8'h00);
          end
          if ($urandom_range(0, 1) == 0) begin
            it.kind = kpsd_pkg::KIND_SCAN;
            it.cols_row1 = quiet_nibble();
            it.cols_row2 = quiet_nibble();
            it.cols_row3 = quiet_nibble();
            it.cols_row4 = quiet_nibble();
            push(it, 1'b0, 8'h00);
          end
          if ($urandom_range(0, 2) != 0) begin
            it = kpsd_pkg::in_item_t'(17'($urandom_range(0, 131071)));
            it.kind = kpsd_pkg::KIND_READ;
            push(it, 1'b0, 8'h00);
          end
        end
        7, 8: begin
          push(kpsd_pkg::in_item_t'(17'($urandom_range(0, 131071))), 1'b0, 8'h00);
        end
        default: begin
          it = kpsd_pkg::in_item_t'(17'($urandom_range(0, 131071)));
          it.kind = kpsd_pkg::KIND_READ;
          push(it, 1'b0, 8'h00);
        end
      endcase
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    foreach (SCRIPT[i]) begin
      push(SCRIPT[i].item, SCRIPT[i].typed, SCRIPT[i].key);
    end
    set_threshold(4'd0);
    run_phase(PHASE_ITEMS, -1);
    set_threshold(kpsd_pkg::COUNT_MAX);
    run_phase(PHASE_ITEMS, 60);
    set_threshold(4'd14);
    run_phase(PHASE_ITEMS, -1);
    set_threshold(4'd1);
    run_phase(PHASE_ITEMS, -1);
    set_threshold(4'($urandom_range(2, 13)));
    run_phase(PHASE_ITEMS, -1);
    set_threshold(kpsd_pkg::THRESHOLD_RESET);
    quiet = 1'b1;
    run_phase(200, -1);
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_keys.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    $display("Sent %0d items and checked %0d results across thresholds 0, 1, 3, 14, 15",
             items_sent, results_checked);
    $display("and one random value; %0d held-key answers, %0d characters read out.",
             held_seen, chars_read);
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
